>>> src/ils_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef logic signed [31:0] data_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	localparam logic [1:0] ORDER_ASC  = 2'd1;
	localparam logic [1:0] ORDER_DESC = 2'd2;
	localparam logic [1:0] ORDER_RESET = ORDER_ASC;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic shift;
		logic sort_en;
		logic descending;
	} cell_ctl_t;

endpackage

`default_nettype wire

>>> src/ils_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ils_in_if;
	import ils_pkg::*;
	logic  valid;
	logic  ready;
	data_t value;
	logic  last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

interface ils_out_if;
	import ils_pkg::*;
	logic  valid;
	logic  ready;
	data_t sorted_value;
	logic  end_of_list;
	logic  status;

	modport source (output valid, output sorted_value, output end_of_list, output status,
		input ready);
	modport sink (input valid, input sorted_value, input end_of_list, input status,
		output ready);
endinterface

`default_nettype wire

>>> src/ils_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ils_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire ils_pkg::cell_ctl_t ctl,
	input  wire                     in_vld,
	input  wire ils_pkg::data_t     in_data,
	input  wire                     nbr_vld,
	input  wire ils_pkg::data_t     nbr_data,
	output logic                    held_vld,
	output ils_pkg::data_t          held_data,
	output logic                    pass_vld,
	output ils_pkg::data_t          pass_data
);
	import ils_pkg::*;

	logic  held_vld_q;
	data_t held_q;
	logic  pass_vld_q;
	data_t pass_q;
	logic  take_new;

	// the incoming value displaces the held one when it ranks earlier; an empty cell always takes it
	always_comb begin
		if (!held_vld_q) begin
			take_new = 1'b1;
		end else if (!ctl.sort_en) begin
			take_new = 1'b0;
		end else if (ctl.descending) begin
			take_new = in_data > held_q;
		end else begin
			take_new = in_data < held_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q <= 1'b0;
			pass_vld_q <= 1'b0;
		end else if (ctl.shift) begin
			held_vld_q <= nbr_vld;
			pass_vld_q <= 1'b0;
		end else if (in_vld) begin
			held_vld_q <= 1'b1;
			pass_vld_q <= held_vld_q;
		end else begin
			pass_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			held_q <= nbr_data;
		end else if (in_vld) begin
			if (take_new) begin
				held_q <= in_data;
				pass_q <= held_q;
			end else begin
				pass_q <= in_data;
			end
		end
	end

	assign held_vld  = held_vld_q;
	assign held_data = held_q;
	assign pass_vld  = pass_vld_q;
	assign pass_data = pass_q;

endmodule

`default_nettype wire

>>> src/ils_chain.sv
`timescale 1ns / 1ps
`default_nettype none

module ils_chain (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire ils_pkg::cell_ctl_t ctl,
	input  wire                     in_vld,
	input  wire ils_pkg::data_t     in_data,
	output ils_pkg::data_t          head_data
);
	import ils_pkg::*;

	logic  held_vld  [MAX_ITEMS];
	data_t held_data [MAX_ITEMS];
	logic  pass_vld  [MAX_ITEMS];
	data_t pass_data [MAX_ITEMS];

	genvar i;
	generate
		for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
			logic  c_in_vld;
			data_t c_in_data;
			logic  c_nbr_vld;
			data_t c_nbr_data;

			if (i == 0) begin : g_head
				assign c_in_vld  = in_vld;
				assign c_in_data = in_data;
			end else begin : g_body
				assign c_in_vld  = pass_vld[i-1];
				assign c_in_data = pass_data[i-1];
			end

			if (i == MAX_ITEMS - 1) begin : g_tail
				assign c_nbr_vld  = 1'b0;
				assign c_nbr_data = '0;
			end else begin : g_inner
				assign c_nbr_vld  = held_vld[i+1];
				assign c_nbr_data = held_data[i+1];
			end

			ils_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.in_vld    (c_in_vld),
				.in_data   (c_in_data),
				.nbr_vld   (c_nbr_vld),
				.nbr_data  (c_nbr_data),
				.held_vld  (held_vld[i]),
				.held_data (held_data[i]),
				.pass_vld  (pass_vld[i]),
				.pass_data (pass_data[i])
			);
		end
	endgenerate

	assign head_data = held_data[0];

endmodule

`default_nettype wire

>>> src/integer_list_sorter.sv
// flow: after the last request of a list the sorter drains while the insertion chain
//   settles, then emits the results and stalls while the receiver is not ready
// throughput: one request per cycle while loading, one result per cycle while emitting;
//   requests are held off from the last request until the last result is registered
// reset: arst_n clears the list, the chain and the output stage; sort order returns to 1
`timescale 1ns / 1ps
`default_nettype none

module integer_list_sorter (
	input  wire              clk,
	input  wire              arst_n,
	ils_in_if.sink           items,
	ils_out_if.source        results,
	input  wire              cfg_we,
	input  wire [1:0]        cfg_wdata
);
	import ils_pkg::*;

	state_t    state_q;
	state_t    state_d;
	logic [1:0] sort_order_q;
	cnt_t      count_q;
	cnt_t      drain_q;
	cnt_t      emit_rem_q;
	logic      status_q;
	logic      out_vld_q;
	data_t     out_data_q;
	logic      out_end_q;
	logic      out_status_q;

	logic      in_ready;
	logic      accept;
	logic      finish;
	logic      out_load;
	cell_ctl_t ctl;
	data_t     head_data;

	assign accept = items.valid && in_ready;
	// a full store ends the list whatever the last flag says
	assign finish = items.last || (count_q == cnt_t'(MAX_ITEMS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (accept && finish) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (drain_q == cnt_t'(1)) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_load && emit_rem_q == cnt_t'(1)) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		out_load       = 1'b0;
		ctl.shift      = 1'b0;
		ctl.sort_en    = (sort_order_q == ORDER_ASC) || (sort_order_q == ORDER_DESC);
		ctl.descending = (sort_order_q == ORDER_DESC);
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
			end
			ST_DRAIN: begin
				in_ready = 1'b0;
			end
			ST_EMIT: begin
				out_load  = (emit_rem_q != '0) && (!out_vld_q || results.ready);
				ctl.shift = out_load;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			sort_order_q <= ORDER_RESET;
			count_q      <= '0;
			drain_q      <= '0;
			emit_rem_q   <= '0;
			status_q     <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) sort_order_q <= cfg_wdata;
			if (accept) begin
				if (finish) begin
					count_q    <= '0;
					drain_q    <= count_q + cnt_t'(1);
					emit_rem_q <= count_q + cnt_t'(1);
					status_q   <= !ctl.sort_en;
				end else begin
					count_q <= count_q + cnt_t'(1);
				end
			end
			if (state_q == ST_DRAIN) drain_q <= drain_q - cnt_t'(1);
			if (out_load) emit_rem_q <= emit_rem_q - cnt_t'(1);
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q   <= head_data;
			out_end_q    <= (emit_rem_q == cnt_t'(1));
			out_status_q <= status_q;
		end
	end

	ils_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.in_vld    (accept),
		.in_data   (items.value),
		.head_data (head_data)
	);

	assign items.ready          = in_ready;
	assign results.valid        = out_vld_q;
	assign results.sorted_value = out_data_q;
	assign results.end_of_list  = out_end_q;
	assign results.status       = out_status_q;

	a_end_flag_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && emit_rem_q != cnt_t'(1)) |=> !results.end_of_list)
		else $error("end of list shown while elements remain");

	a_last_request_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && finish) |=> (state_q == ST_DRAIN && count_q == '0))
		else $error("final request did not start the drain");

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (emit_rem_q == '0))
		else $error("loading while a list is still pending");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < cnt_t'(MAX_ITEMS))
		else $error("element count past the store size");

endmodule

`default_nettype wire

>>> test/tb_integer_list_sorter.sv
`timescale 1ns / 1ps

module tb_integer_list_sorter;
	import ils_pkg::*;

	// order codes that leave the list in arrival order
	localparam logic [1:0] ORDER_KEEP_LO = 2'd0;
	localparam logic [1:0] ORDER_KEEP_HI = 2'd3;
	localparam logic       STATUS_SORTED    = 1'b0;
	localparam logic       STATUS_BAD_ORDER = 1'b1;

	localparam int SETTLE_CYCLES  = 100;
	localparam int HOLD_CYCLES    = 300;
	localparam int SEGMENT_ITEMS  = 14;
	localparam int TIMEOUT_NS     = 4_000_000;

	typedef struct {
		data_t value;
		logic  last;
	} request_t;

	typedef struct {
		data_t value;
		logic  end_flag;
		logic  status;
	} sorted_word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_wdata;

	ils_in_if  item_bus ();
	ils_out_if result_bus ();

	integer_list_sorter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (item_bus),
		.results  (result_bus),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	request_t     pending_requests[$];
	sorted_word_t expected_words[$];

	// predictor state
	data_t       list_store[MAX_ITEMS];
	int unsigned list_len;
	logic [1:0]  model_order;

	int  send_idle_pct;
	int  recv_idle_pct;
	bit  hold_armed;
	bit  hold_done;
	int  hold_left;
	logic in_fire;
	request_t next_req;

	int error_count;
	int requests_taken;
	int words_checked;
	int lists_closed;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic void predict_request(data_t v, logic lst);
		data_t t;
		int unsigned n;
		logic bad;
		logic swap;
		if (list_len >= MAX_ITEMS)
			list_len = 0;
		list_store[list_len] = v;
		list_len++;
		if (!lst && list_len < MAX_ITEMS)
			return;
		n = list_len;
		bad = !(model_order == ORDER_ASC || model_order == ORDER_DESC);
		if (!bad) begin
			for (int i = 0; i < n; i++) begin
				for (int j = i + 1; j < n; j++) begin
					swap = (model_order == ORDER_DESC) ? (list_store[j] > list_store[i])
						: (list_store[i] > list_store[j]);
					if (swap) begin
						t = list_store[i];
						list_store[i] = list_store[j];
						list_store[j] = t;
					end
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			expected_words.push_back('{list_store[k], k == n - 1,
				bad ? STATUS_BAD_ORDER : STATUS_SORTED});
		end
		list_len = 0;
	endfunction

	function automatic data_t pick_value();
		data_t v;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: v = 32'sh7fff_ffff;
					1: v = 32'sh8000_0000;
					2: v = '0;
					default: v = '1;
				endcase
			end
			// narrow range so that lists carry duplicates
			1, 2, 3: v = data_t'($urandom_range(8)) - data_t'(4);
			default: v = data_t'($urandom);
		endcase
		return v;
	endfunction

	task automatic add_request(data_t v, logic lst);
		pending_requests.push_back('{v, lst});
	endtask

	task automatic add_random_list(int len);
		for (int i = 0; i < len; i++)
			add_request(pick_value(), i == len - 1);
	endtask

	// a list that reaches the store limit; with len 64 the last flag may be absent
	task automatic add_long_list(int len);
		logic lst;
		for (int i = 0; i < len; i++) begin
			if (i != len - 1)
				lst = 1'b0;
			else
				lst = (len == MAX_ITEMS) ? logic'($urandom_range(1)) : 1'b1;
			add_request(pick_value(), lst);
		end
	endtask

	task automatic drain_and_settle();
		while (pending_requests.size() != 0 || item_bus.valid || expected_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_order(logic [1:0] code);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= code;
		@(negedge clk);
		cfg_we    <= 1'b0;
		model_order = code;
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_bus.valid || in_fire) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = pending_requests.pop_front();
					item_bus.valid <= 1'b1;
					item_bus.value <= next_req.value;
					item_bus.last  <= next_req.last;
				end else begin
					item_bus.valid <= 1'b0;
				end
			end
		end
	end

	// result receiver, with one long hold-off once armed
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				result_bus.ready <= 1'b0;
			end else if (hold_armed && !hold_done && result_bus.valid) begin
				hold_done = 1'b1;
				hold_left <= HOLD_CYCLES;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// monitor: predict on accepted requests, check accepted results
	always @(posedge clk) begin
		in_fire <= arst_n && item_bus.valid && item_bus.ready;
		if (arst_n && item_bus.valid && item_bus.ready) begin
			predict_request(item_bus.value, item_bus.last);
			requests_taken++;
		end
		if (arst_n && result_bus.valid && result_bus.ready) begin
			words_checked++;
			if (result_bus.end_of_list)
				lists_closed++;
			if (expected_words.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result: expected none, got value %0d end %0b status %0b",
					$time, result_bus.sorted_value, result_bus.end_of_list, result_bus.status);
			end else begin
				sorted_word_t exp_w;
				exp_w = expected_words.pop_front();
				if (result_bus.sorted_value !== exp_w.value
						|| result_bus.end_of_list !== exp_w.end_flag
						|| result_bus.status !== exp_w.status) begin
					error_count++;
					$display("%0t: mismatch: expected value %0d end %0b status %0b, got value %0d end %0b status %0b",
						$time, exp_w.value, exp_w.end_flag, exp_w.status,
						result_bus.sorted_value, result_bus.end_of_list, result_bus.status);
				end
			end
		end
	end

	initial begin
		logic [1:0] seg_codes[4];
		int budget;

		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = ORDER_ASC;
		item_bus.valid   = 1'b0;
		item_bus.value   = '0;
		item_bus.last    = 1'b0;
		result_bus.ready = 1'b0;
		in_fire          = 1'b0;
		hold_armed       = 1'b0;
		hold_done        = 1'b0;
		hold_left        = 0;
		list_len         = 0;
		model_order      = ORDER_ASC;
		error_count      = 0;
		requests_taken   = 0;
		words_checked    = 0;
		lists_closed     = 0;
		send_idle_pct    = 38;
		recv_idle_pct    = 48;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed lists, ascending from reset
		add_request(32'sh7fff_ffff, 1'b0);
		add_request(32'sh8000_0000, 1'b0);
		add_request(32'sh0000_0000, 1'b0);
		add_request(-32'sd1, 1'b0);
		add_request(32'sd1, 1'b0);
		add_request(32'sd5, 1'b0);
		add_request(32'sd5, 1'b1);
		add_request(-32'sd1, 1'b1);
		drain_and_settle();

		write_order(ORDER_DESC);
		add_request(32'sh0000_0000, 1'b0);
		add_request(32'sh8000_0000, 1'b0);
		add_request(32'sh7fff_ffff, 1'b0);
		add_request(-32'sd7, 1'b0);
		add_request(-32'sd7, 1'b0);
		add_request(32'sd3, 1'b1);
		drain_and_settle();

		write_order(ORDER_KEEP_LO);
		add_request(32'sd3, 1'b0);
		add_request(-32'sd2, 1'b0);
		add_request(32'sh8000_0000, 1'b0);
		add_request(32'sh7fff_ffff, 1'b1);
		drain_and_settle();

		write_order(ORDER_KEEP_HI);
		add_request(32'sd9, 1'b0);
		add_request(32'sd9, 1'b0);
		add_request(32'sd0, 1'b1);
		drain_and_settle();

		// random lists: receiver-heavy idling, sender-heavy idling, then none with one long result hold-off
		seg_codes = '{ORDER_ASC, ORDER_DESC, ORDER_KEEP_LO, ORDER_KEEP_HI};
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin send_idle_pct = 38; recv_idle_pct = 48; end
				1: begin send_idle_pct = 48; recv_idle_pct = 38; end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_armed = 1'b1;
				end
			endcase
			for (int seg = 0; seg < 4; seg++) begin
				write_order(seg_codes[(seg + mode) % 4]);
				if (seg == 1)
					add_long_list(MAX_ITEMS + $urandom_range(0, 5));
				budget = SEGMENT_ITEMS;
				while (budget > 0) begin
					int len;
					len = $urandom_range(1, 12);
					add_random_list(len);
					budget -= len;
				end
				drain_and_settle();
			end
		end

		$display("run covered %0d requests in %0d lists, %0d sorted words checked,",
			requests_taken, lists_closed, words_checked);
		$display("under all four order codes, full-store lists and a long result stall");
		if (error_count == 0 && expected_words.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
src/ils_pkg.sv
src/ils_if.sv
src/ils_cell.sv
src/ils_chain.sv
src/integer_list_sorter.sv
test/tb_integer_list_sorter.sv
